### sv/b2g_pkg.sv
`default_nettype none

package b2g_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_HEIGHT = 2'd1;

    localparam int FRAME_WIDTH_W  = 10;
    localparam int FRAME_HEIGHT_W = 13;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 10'd318;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd425;

    // Row position
    localparam int ROW_W        = 12;
    localparam int HEIGHT_LIMIT = 4096;

    // Payload widths
    localparam int GLYPH_W = 8;
    localparam int COUNT_W = 3;
    localparam int PAIR_W  = 2;

    // Glyph codes
    localparam logic [GLYPH_W-1:0] GLYPH_EMPTY = 8'h41;  // 'A'
    localparam logic [GLYPH_W-1:0] GLYPH_ONE   = 8'h4C;  // 'L'
    localparam logic [GLYPH_W-1:0] GLYPH_TWO   = 8'h2F;  // '/'
    localparam logic [GLYPH_W-1:0] GLYPH_THREE = 8'h2E;  // '.'
    localparam logic [GLYPH_W-1:0] GLYPH_FULL  = 8'h20;  // ' '

    typedef struct packed {
        logic col_odd;
        logic row_odd;
        logic row_end;
        logic frame_end;
    } t_scan_flags;

    function automatic logic [GLYPH_W-1:0] glyph_of_count(input logic [COUNT_W-1:0] count);
        logic [GLYPH_W-1:0] g;
        unique case (count)
            3'd0:    g = GLYPH_EMPTY;
            3'd1:    g = GLYPH_ONE;
            3'd2:    g = GLYPH_TWO;
            3'd3:    g = GLYPH_THREE;
            default: g = GLYPH_FULL;  // saturate at a full block
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

### sv/b2g_pix_if.sv
`default_nettype none

interface b2g_pix_if;
    logic valid;
    logic ready;
    logic pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

### sv/b2g_glyph_if.sv
`default_nettype none

interface b2g_glyph_if;
    logic       valid;
    logic       ready;
    logic [7:0] glyph;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, output glyph, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input glyph, input row_end, input frame_end,
                    output ready);
endinterface

`default_nettype wire

### sv/b2g_scan.sv
`default_nettype none

module b2g_scan
    import b2g_pkg::*;
#(
    parameter int COL_W = 9
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic             i_restart,
    input  wire logic             i_pixel,
    input  wire logic [COL_W-1:0] i_col_max,
    input  wire logic [COL_W-1:0] i_last_col,
    input  wire logic [ROW_W-1:0] i_row_max,
    input  wire logic [ROW_W-1:0] i_last_row,
    output logic      [COL_W-1:0] o_col,
    output logic                  o_left,
    output t_scan_flags           o_flags
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_left, n_left;

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_left = r_left;
        priority if (i_restart) begin
            n_col  = '0;
            n_row  = '0;
            n_left = 1'b0;
        end else if (i_step) begin
            if (!r_col[0]) begin
                n_left = i_pixel;
            end
            if (r_col == i_col_max) begin
                n_col = '0;
                n_row = (r_row == i_row_max) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end else begin
            // hold position between transactions
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_left <= n_left;
        end
    end

    always_comb begin
        o_flags.col_odd   = r_col[0];
        o_flags.row_odd   = r_row[0];
        o_flags.row_end   = (r_col == i_last_col);
        o_flags.frame_end = (r_col == i_last_col) && (r_row == i_last_row);
    end

    assign o_col  = r_col;
    assign o_left = r_left;

endmodule

`default_nettype wire

### sv/b2g_line_buf.sv
`default_nettype none

module b2g_line_buf
    import b2g_pkg::*;
#(
    parameter int SLOTS  = 256,
    parameter int ADDR_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [PAIR_W-1:0] i_wr_data,
    output logic      [PAIR_W-1:0] o_rd_data
);

    logic [PAIR_W-1:0] r_mem [SLOTS];
    logic [PAIR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    // Hold the read word until the next read of the odd row.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### sv/b2g_out_stage.sv
`default_nettype none

module b2g_out_stage
    import b2g_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire logic [PAIR_W-1:0]  i_upper_pair,
    input  wire logic               i_left,
    input  wire logic               i_pixel,
    input  wire logic               i_row_end,
    input  wire logic               i_frame_end,
    input  wire logic               i_ready,
    output logic                    o_can_take,
    output logic                    o_valid,
    output logic      [GLYPH_W-1:0] o_glyph,
    output logic                    o_row_end,
    output logic                    o_frame_end
);

    logic               r_valid, n_valid;
    logic [GLYPH_W-1:0] r_glyph;
    logic               r_row_end;
    logic               r_frame_end;
    logic [COUNT_W-1:0] block_count;

    assign block_count = COUNT_W'(i_upper_pair) + COUNT_W'(i_left) + COUNT_W'(i_pixel);

    assign o_can_take = !r_valid || i_ready;
    assign n_valid    = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_glyph     <= glyph_of_count(block_count);
            r_row_end   <= i_row_end;
            r_frame_end <= i_frame_end;
        end
    end

    assign o_valid     = r_valid;
    assign o_glyph     = r_glyph;
    assign o_row_end   = r_row_end;
    assign o_frame_end = r_frame_end;

endmodule

`default_nettype wire

### sv/binary_image_2x2_bin_to_glyph_unit.sv
// A glyph is valid in the cycle after the bottom-right pixel of its block is accepted.
// Throughput: one pixel per cycle; the result register frees when its glyph is taken,
// so input stalls only while a glyph waits untaken.
// Reset: scan position and left pixel clear, frame_width = 318, frame_height = 425.
// The line buffer is not cleared; an even row always fills a slot before the row below reads it.
`default_nettype none

module binary_image_2x2_bin_to_glyph_unit
    import b2g_pkg::*;
#(
    parameter int MAX_WIDTH = 512
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    b2g_pix_if.sink                    i_pix,
    b2g_glyph_if.source                o_glyph
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int SLOTS  = MAX_WIDTH / 2;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    function automatic logic [31:0] eff_width(input logic [FRAME_WIDTH_W-1:0] w);
        logic [31:0] v;
        v = 32'(w);
        if (v < 32'd2) v = 32'd2;
        else if (v > 32'(MAX_WIDTH)) v = 32'(MAX_WIDTH);
        return v;
    endfunction

    function automatic logic [31:0] eff_height(input logic [FRAME_HEIGHT_W-1:0] h);
        logic [31:0] v;
        v = 32'(h);
        if (v < 32'd2) v = 32'd2;
        else if (v > 32'(HEIGHT_LIMIT)) v = 32'(HEIGHT_LIMIT);
        return v;
    endfunction

    // Configuration: keep the clamped limits in the form the scan compares against
    logic [31:0]      w_new, h_new, w_rst, h_rst;
    logic [31:0]      last_col_new, last_row_new, last_col_rst, last_row_rst;
    logic [COL_W-1:0] r_col_max, r_last_col;
    logic [ROW_W-1:0] r_row_max, r_last_row;
    logic             cfg_width_wr, cfg_height_wr, restart;

    always_comb begin
        w_new        = eff_width(i_cfg_data[FRAME_WIDTH_W-1:0]);
        h_new        = eff_height(i_cfg_data[FRAME_HEIGHT_W-1:0]);
        w_rst        = eff_width(FRAME_WIDTH_RST);
        h_rst        = eff_height(FRAME_HEIGHT_RST);
        last_col_new = (w_new & ~32'd1) - 32'd1;
        last_row_new = (h_new & ~32'd1) - 32'd1;
        last_col_rst = (w_rst & ~32'd1) - 32'd1;
        last_row_rst = (h_rst & ~32'd1) - 32'd1;
    end

    assign cfg_width_wr  = i_cfg_we && (i_cfg_idx == CFG_IDX_FRAME_WIDTH);
    assign cfg_height_wr = i_cfg_we && (i_cfg_idx == CFG_IDX_FRAME_HEIGHT);
    assign restart       = cfg_width_wr || cfg_height_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_max  <= COL_W'(w_rst - 32'd1);
            r_last_col <= COL_W'(last_col_rst);
            r_row_max  <= ROW_W'(h_rst - 32'd1);
            r_last_row <= ROW_W'(last_row_rst);
        end else begin
            if (cfg_width_wr) begin
                r_col_max  <= COL_W'(w_new - 32'd1);
                r_last_col <= COL_W'(last_col_new);
            end
            if (cfg_height_wr) begin
                r_row_max  <= ROW_W'(h_new - 32'd1);
                r_last_row <= ROW_W'(last_row_new);
            end
        end
    end

    // Scan position
    logic             accept;
    logic             can_take;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] col_half;
    logic [ADDR_W-1:0] slot;
    logic             left;
    t_scan_flags      flags;

    assign i_pix.ready = can_take;
    assign accept      = i_pix.valid && can_take;

    b2g_scan #(
        .COL_W (COL_W)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (accept),
        .i_restart  (restart),
        .i_pixel    (i_pix.pixel),
        .i_col_max  (r_col_max),
        .i_last_col (r_last_col),
        .i_row_max  (r_row_max),
        .i_last_row (r_last_row),
        .o_col      (col),
        .o_left     (left),
        .o_flags    (flags)
    );

    assign col_half = col >> 1;
    assign slot     = col_half[ADDR_W-1:0];

    // Line buffer: even rows store pair sums, odd rows fetch them on the even column
    logic              lb_wr, lb_rd;
    logic [PAIR_W-1:0] pair_now;
    logic [PAIR_W-1:0] upper_pair;

    assign pair_now = PAIR_W'(left) + PAIR_W'(i_pix.pixel);
    assign lb_wr    = accept && flags.col_odd && !flags.row_odd;
    assign lb_rd    = accept && !flags.col_odd && flags.row_odd;

    b2g_line_buf #(
        .SLOTS  (SLOTS),
        .ADDR_W (ADDR_W)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (lb_wr),
        .i_rd_en   (lb_rd),
        .i_addr    (slot),
        .i_wr_data (pair_now),
        .o_rd_data (upper_pair)
    );

    // Result register
    logic load;

    assign load = accept && flags.col_odd && flags.row_odd;

    b2g_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_upper_pair (upper_pair),
        .i_left       (left),
        .i_pixel      (i_pix.pixel),
        .i_row_end    (flags.row_end),
        .i_frame_end  (flags.frame_end),
        .i_ready      (o_glyph.ready),
        .o_can_take   (can_take),
        .o_valid      (o_glyph.valid),
        .o_glyph      (o_glyph.glyph),
        .o_row_end    (o_glyph.row_end),
        .o_frame_end  (o_glyph.frame_end)
    );

    // Checks
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && o_glyph.valid && !o_glyph.ready))
        else $error("pixel accepted while a stalled glyph would be overwritten");

    a_block_done_gives_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> o_glyph.valid)
        else $error("finished block produced no glyph");

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        col <= r_col_max)
        else $error("column position past end of row");

    a_frame_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_glyph.valid && o_glyph.frame_end) |-> o_glyph.row_end)
        else $error("frame end flagged away from a row end");

endmodule

`default_nettype wire

### tb/binary_image_2x2_bin_to_glyph_unit_test.sv
`default_nettype none

module binary_image_2x2_bin_to_glyph_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import b2g_pkg::*;

    localparam int MAX_WIDTH     = 512;
    localparam int PAIR_SLOTS    = MAX_WIDTH / 2;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int SETTLE_CYCLES = 3;
    localparam int STALL_LIMIT   = 200;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic               row_end;
        logic               frame_end;
    } t_glyph_beat;

    // Tracks the scan position and the line of pair sums, and keeps the glyphs still owed.
    class block_glyph_tracker;
        logic [FRAME_WIDTH_W-1:0]  frame_width;
        logic [FRAME_HEIGHT_W-1:0] frame_height;
        int unsigned               scan_col;
        int unsigned               scan_row;
        logic                      left_bit;
        logic [PAIR_W-1:0]         pair_sum [PAIR_SLOTS];
        t_glyph_beat               glyphs_due [$];
        int                        errors;

        function void restart();
            scan_col = 0;
            scan_row = 0;
            left_bit = 1'b0;
        endfunction

        function void clear();
            frame_width  = FRAME_WIDTH_RST;
            frame_height = FRAME_HEIGHT_RST;
            restart();
            foreach (pair_sum[i]) pair_sum[i] = '0;
            glyphs_due.delete();
            errors = 0;
        endfunction

        function int unsigned eff_width();
            int unsigned w;
            w = 32'(frame_width);
            if (w < 2) w = 2;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            return w;
        endfunction

        function int unsigned eff_height();
            int unsigned h;
            h = 32'(frame_height);
            if (h < 2) h = 2;
            if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
            return h;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IDX_FRAME_WIDTH: begin
                    frame_width = data[FRAME_WIDTH_W-1:0];
                    restart();
                end
                CFG_IDX_FRAME_HEIGHT: begin
                    frame_height = data[FRAME_HEIGHT_W-1:0];
                    restart();
                end
                default: ;
            endcase
        endfunction

        function void take_pixel(logic p);
            int unsigned        w;
            int unsigned        h;
            int unsigned        slot;
            logic [COUNT_W-1:0] count;
            t_glyph_beat        beat;
            w    = eff_width();
            h    = eff_height();
            slot = scan_col / 2;
            if (scan_col % 2 == 0) begin
                left_bit = p;
            end else if (scan_row % 2 == 0) begin
                pair_sum[slot] = PAIR_W'(left_bit) + PAIR_W'(p);
            end else begin
                count = COUNT_W'(pair_sum[slot]) + COUNT_W'(left_bit) + COUNT_W'(p);
                case (count)
                    0:       beat.glyph = GLYPH_EMPTY;
                    1:       beat.glyph = GLYPH_ONE;
                    2:       beat.glyph = GLYPH_TWO;
                    3:       beat.glyph = GLYPH_THREE;
                    default: beat.glyph = GLYPH_FULL;
                endcase
                // an odd trailing column or row never reaches these positions
                beat.row_end   = (scan_col == (w / 2) * 2 - 1);
                beat.frame_end = beat.row_end && (scan_row == (h / 2) * 2 - 1);
                glyphs_due.push_back(beat);
            end
            if (scan_col + 1 >= w) begin
                scan_col = 0;
                scan_row = (scan_row + 1 >= h) ? 0 : scan_row + 1;
            end else begin
                scan_col = scan_col + 1;
            end
        endfunction

        function void match_glyph(logic [GLYPH_W-1:0] glyph, logic row_end, logic frame_end);
            t_glyph_beat due;
            if (glyphs_due.size() == 0) begin
                $display("%0t: unexpected glyph %h row_end %b frame_end %b",
                         $time, glyph, row_end, frame_end);
                errors++;
                return;
            end
            due = glyphs_due.pop_front();
            if (glyph !== due.glyph) begin
                $display("%0t: glyph expected %h actual %h", $time, due.glyph, glyph);
                errors++;
            end
            if (row_end !== due.row_end) begin
                $display("%0t: row_end expected %b actual %b", $time, due.row_end, row_end);
                errors++;
            end
            if (frame_end !== due.frame_end) begin
                $display("%0t: frame_end expected %b actual %b",
                         $time, due.frame_end, frame_end);
                errors++;
            end
        endfunction

        function int pending();
            return glyphs_due.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    b2g_pix_if   pix_bus ();
    b2g_glyph_if glyph_bus ();

    block_glyph_tracker tracker;
    bit                 src_calm;
    bit                 snk_calm;
    int                 idle_cycles = 0;

    binary_image_2x2_bin_to_glyph_unit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_bus),
        .o_glyph    (glyph_bus)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Results are checked before the pixel of the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (glyph_bus.valid && glyph_bus.ready)
                tracker.match_glyph(glyph_bus.glyph, glyph_bus.row_end, glyph_bus.frame_end);
            if (pix_bus.valid && pix_bus.ready)
                tracker.take_pixel(pix_bus.pixel);
            if (i_cfg_we)
                tracker.write_reg(i_cfg_idx, i_cfg_data);
        end
    end

    always @(posedge i_clk) begin
        if ((pix_bus.valid && pix_bus.ready) || (glyph_bus.valid && glyph_bus.ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Glyph receiver: unless snk_calm is set, stall a random number of cycles before each transaction.
    initial begin
        int stall;
        glyph_bus.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = snk_calm ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                glyph_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            glyph_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!glyph_bus.valid);
        end
    end

    task automatic send_pixel(input logic p);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            pix_bus.valid <= 1'b0;
            pix_bus.pixel <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.pixel <= p;
        do @(posedge i_clk); while (!pix_bus.ready);
    endtask

    // Hold the pixel stream until every owed glyph has been taken.
    task automatic settle();
        pix_bus.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // which: 0 width, 1 height, 2 both, 3 both followed by writes to unused indexes
    task automatic reprogram(input int which, input logic [CFG_DATA_W-1:0] width_data,
                             input logic [CFG_DATA_W-1:0] height_data);
        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (which != 1) cfg_write(CFG_IDX_FRAME_WIDTH, width_data);
        if (which != 0) cfg_write(CFG_IDX_FRAME_HEIGHT, height_data);
        if (which == 3) begin
            cfg_write(CFG_IDX_FRAME_HEIGHT + 1'b1, CFG_DATA_W'($urandom));
            cfg_write(CFG_IDX_FRAME_HEIGHT + 2'd2, CFG_DATA_W'($urandom));
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic draw_pixel(input int density);
        case (density)
            1:       return $urandom_range(0, 3) != 0;
            2:       return $urandom_range(0, 3) == 0;
            default: return 1'($urandom_range(0, 1));
        endcase
    endfunction

    initial begin
        logic [0:19] strip;
        logic [0:8]  tiny;
        int unsigned w;
        int unsigned h;
        int unsigned ew;
        int unsigned eh;
        int          n;
        int          which;
        int          density;
        int          sent;

        tracker = new;
        tracker.clear();
        pix_bus.valid <= 1'b0;
        pix_bus.pixel <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        src_calm = 1'b1;
        snk_calm = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b0 | 1'b1;

        // One strip of five blocks with counts 0, 1, 3, 2, 4.
        strip = 20'b0010111011_0000100111;
        reprogram(2, CFG_DATA_W'(10), CFG_DATA_W'(2));
        foreach (strip[k]) send_pixel(strip[k]);

        // Odd width and height: trailing column and row give nothing.
        tiny = 9'b110_101_011;
        src_calm = 1'b0;
        snk_calm = 1'b0;
        reprogram(3, CFG_DATA_W'(3), CFG_DATA_W'(3));
        foreach (tiny[k]) send_pixel(tiny[k]);

        // Width above the line limit acts as the limit; run one full frame of it.
        sent = 0;
        w = $urandom_range(MAX_WIDTH + 1, 1023);
        reprogram(2, CFG_DATA_W'(($urandom_range(0, 7) << FRAME_WIDTH_W) | w),
                  CFG_DATA_W'($urandom_range(0, 2)));
        density = $urandom_range(0, 3);
        for (int k = 0; k < 2 * MAX_WIDTH; k++) send_pixel(draw_pixel(density));
        sent += 2 * MAX_WIDTH;

        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 1);
                1:       w = $urandom_range(17, 48);
                default: w = $urandom_range(2, 16);
            endcase
            case ($urandom_range(0, 9))
                0:       h = $urandom_range(0, 1);
                1:       h = $urandom_range(HEIGHT_LIMIT, 8191);
                default: h = $urandom_range(2, 9);
            endcase
            which = $urandom_range(0, 3);
            if (tracker.eff_width() > 48) which = 2;
            reprogram(which, CFG_DATA_W'(($urandom_range(0, 7) << FRAME_WIDTH_W) | w),
                      CFG_DATA_W'(h));
            ew = tracker.eff_width();
            eh = tracker.eff_height();
            if (ew * eh <= 160)
                n = ew * eh * $urandom_range(1, 2) + $urandom_range(0, 2 * ew);
            else
                n = $urandom_range(2 * ew, 4 * ew);
            density  = $urandom_range(0, 3);
            src_calm = ($urandom_range(0, 3) == 0);
            snk_calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 149) == 0) settle();
                send_pixel(draw_pixel(density));
            end
            sent += n;
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
